@@ design/vfs_pkg.sv @@
// Package for the vector float sine block: widths, float constants and a helper function.
`timescale 1ns / 1ps
package vfs_pkg;

	localparam int F32W      = 32;
	localparam int LANES_DEF = 4;
	localparam int FMA_LAT   = 5;
	localparam int FMA_COUNT = 11;
	localparam int LANE_LAT  = FMA_COUNT * FMA_LAT;

	// Exponent arithmetic width inside the fused multiply-add
	localparam int EXW = 12;
	// Alignment window: carry bit, 48-bit big operand, 52 extension bits, sticky bit
	localparam int WINW = 102;
	localparam int RNDW = WINW + 2;

	// Exponent given to a zero operand so that it loses the alignment compare to any nonzero operand
	localparam logic signed [EXW-1:0] EXP_ZERO = -12'sd1024;

	// binary32 bit patterns of the constants
	localparam logic [F32W-1:0] ABS_MASK    = 32'h7fffffff;
	localparam logic [F32W-1:0] RANGE_BITS  = 32'h49800000;
	localparam logic [F32W-1:0] SHIFT_K     = 32'h4b400000;
	localparam logic [F32W-1:0] INV_PI      = 32'h3ea2f983;
	localparam logic [F32W-1:0] NEG_ONE     = 32'hbf800000;
	localparam logic [F32W-1:0] FZERO       = 32'h00000000;
	localparam logic [F32W-1:0] NEG_PI_HI   = 32'hc0490fdb;
	localparam logic [F32W-1:0] NEG_PI_MID  = 32'h33bbbd2e;
	localparam logic [F32W-1:0] NEG_PI_LO   = 32'h27772ced;
	localparam logic [F32W-1:0] C3          = 32'hbe2aaaa4;
	localparam logic [F32W-1:0] C5          = 32'h3c0886fa;
	localparam logic [F32W-1:0] C7          = 32'hb94fa175;
	localparam logic [F32W-1:0] C9          = 32'h362d973b;

	// Index of the highest set bit of the alignment window (0 when empty)
	function automatic logic [6:0] msb_index(input logic [WINW-1:0] v);
		logic [6:0] p;
		p = 7'd0;
		for (int i = 0; i < WINW; i++) begin
			if (v[i]) p = 7'(i);
		end
		return p;
	endfunction

endpackage

@@ design/vector_float_sine.sv @@
// Top level of the vector float sine block: lanes, valid pipeline and stream ports.
// Takes one request of LANES binary32 angles per cycle and returns their sines
// after eleven chained fused multiply-adds of five register stages each; a new
// request is accepted every cycle while the result side takes its
// data. A stall on the result side freezes the whole pipeline in place. Lanes with
// |x| >= 2^20, infinity or NaN return 0 and set their bit in out_of_range_mask.
// All arithmetic rounds to nearest even and keeps subnormals.
`timescale 1ns / 1ps
module vector_float_sine import vfs_pkg::*; #(
	parameter int LANES = LANES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// x_lane0 .. x_lane(LANES-1), 32 bits each, lane 0 lowest
	input  logic [F32W*LANES-1:0]                s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// sine_lane0 .. sine_lane(LANES-1), 32 bits each, then out_of_range_mask, zero fill
	output logic [(((F32W+1)*LANES+7)/8)*8-1:0] m_tdata
);

	localparam int OUTW = (((F32W + 1) * LANES + 7) / 8) * 8;
	localparam int PADW = OUTW - (F32W + 1) * LANES;

	logic                   en;
	logic [LANE_LAT-1:0]    vld_s;
	logic [F32W*LANES-1:0]  sine_all;
	logic [LANES-1:0]       oor_all;

	// Advance when the output slot is free or being taken
	assign en       = !vld_s[LANE_LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s[LANE_LAT-1];

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LANE_LAT-2:0], s_tvalid};
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		vfs_lane u_lane (
			.clk,
			.en,
			.x(s_tdata[F32W*i +: F32W]),
			.sine(sine_all[F32W*i +: F32W]),
			.oor(oor_all[i])
		);
	end

	if (PADW > 0) begin : g_pad
		assign m_tdata = {{PADW{1'b0}}, oor_all, sine_all};
	end else begin : g_nopad
		assign m_tdata = {oor_all, sine_all};
	end

	// A flagged lane 0 always reads zero
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && oor_all[0] |-> sine_all[F32W-1:0] == FZERO)
		else $error("flagged lane 0 carries a nonzero sine");

	// A stall freezes every valid bit
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("valid pipeline moved during a stall");

	// A bubble ahead of the last stage reaches the output
	a_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		en && !vld_s[LANE_LAT-2] |=> !m_tvalid)
		else $error("result appeared without a request behind it");

	// Nothing accepted while the output is stalled
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request accepted while result stalled");

endmodule

@@ design/vfs_delay.sv @@
// Stall-aware delay line that holds side data level with the arithmetic pipeline.
`timescale 1ns / 1ps
module vfs_delay import vfs_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	// Advance the taps whenever the pipeline moves
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

@@ design/vfs_fma.sv @@
// Five-stage binary32 fused multiply-add y = a + b*c, round to nearest even.
`timescale 1ns / 1ps
module vfs_fma import vfs_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [F32W-1:0] a,
	input  logic [F32W-1:0] b,
	input  logic [F32W-1:0] c,
	output logic [F32W-1:0] y
);

	// Stage 1: unpack and multiply
	logic [7:0]  ea, eb, ec, ea_c, eb_c, ec_c;
	logic [23:0] ma, mb, mc;
	logic signed [EXW-1:0] exp_p, exp_a;

	assign ea   = a[30:23];
	assign eb   = b[30:23];
	assign ec   = c[30:23];
	assign ma   = {|ea, a[22:0]};
	assign mb   = {|eb, b[22:0]};
	assign mc   = {|ec, c[22:0]};
	assign ea_c = (ea == 8'd0) ? 8'd1 : ea;
	assign eb_c = (eb == 8'd0) ? 8'd1 : eb;
	assign ec_c = (ec == 8'd0) ? 8'd1 : ec;
	assign exp_p = $signed({4'd0, eb_c}) + $signed({4'd0, ec_c}) - 12'sd300;
	assign exp_a = $signed({4'd0, ea_c}) - 12'sd174;

	logic [47:0]           prod_s1;
	logic [23:0]           ma_s1;
	logic                  sa_s1, sp_s1, zp_s1, za_s1;
	logic signed [EXW-1:0] ep_s1, ea_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= mb * mc;
			ma_s1   <= ma;
			sa_s1   <= a[31];
			sp_s1   <= b[31] ^ c[31];
			zp_s1   <= (mb == 24'd0) || (mc == 24'd0);
			za_s1   <= (ma == 24'd0);
			ep_s1   <= exp_p;
			ea_s1   <= exp_a;
		end
	end

	// Stage 2: pick the operand with the larger exponent and align the other
	logic signed [EXW-1:0] ep_x, ea_x, exp_big;
	logic                  p_big;
	logic [47:0]           big_m, small_m;
	logic [EXW:0]          exp_gap;
	logic [6:0]            sh_al;
	logic [WINW-1:0]       small_w, shifted, al_mask, aligned;
	logic                  al_stk;

	always_comb begin
		ep_x    = zp_s1 ? EXP_ZERO : ep_s1;
		ea_x    = za_s1 ? EXP_ZERO : ea_s1;
		p_big   = (ep_x >= ea_x);
		big_m   = p_big ? prod_s1 : {ma_s1, 24'd0};
		small_m = p_big ? {ma_s1, 24'd0} : prod_s1;
		exp_big = p_big ? ep_x : ea_x;
		exp_gap = p_big ? ({ep_x[EXW-1], ep_x} - {ea_x[EXW-1], ea_x})
		                : ({ea_x[EXW-1], ea_x} - {ep_x[EXW-1], ep_x});
		sh_al   = (exp_gap > 13'(WINW)) ? 7'(WINW) : exp_gap[6:0];
		small_w = {1'b0, small_m, 53'd0};
		shifted = small_w >> sh_al;
		al_mask = ({{(WINW-1){1'b0}}, 1'b1} << ({1'b0, sh_al} + 8'd1)) - WINW'(1);
		al_stk  = |(small_w & al_mask);
		aligned = {shifted[WINW-1:1], shifted[0] | al_stk};
	end

	logic [WINW-1:0]       big_s2, al_s2;
	logic                  sub_s2, sgn_s2, bz_s2, zs_s2;
	logic signed [EXW-1:0] exp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			big_s2 <= {1'b0, big_m, 53'd0};
			al_s2  <= aligned;
			sub_s2 <= sp_s1 ^ sa_s1;
			sgn_s2 <= p_big ? sp_s1 : sa_s1;
			bz_s2  <= zp_s1 && za_s1;
			zs_s2  <= sp_s1 && sa_s1;
			exp_s2 <= exp_big;
		end
	end

	// Stage 3: add or subtract, take the magnitude
	logic [WINW:0]   raw;
	logic            neg;
	logic [WINW-1:0] mag;
	logic            sum_sign;

	always_comb begin
		raw = sub_s2 ? ({1'b0, big_s2} - {1'b0, al_s2}) : ({1'b0, big_s2} + {1'b0, al_s2});
		neg = raw[WINW] & sub_s2;
		mag = neg ? (~raw[WINW-1:0] + WINW'(1)) : raw[WINW-1:0];
		if (mag == '0) sum_sign = bz_s2 ? zs_s2 : 1'b0;
		else           sum_sign = sgn_s2 ^ neg;
	end

	logic [WINW-1:0]       mag_s3;
	logic                  sign_s3, zero_s3;
	logic signed [EXW-1:0] exp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= mag;
			sign_s3 <= sum_sign;
			zero_s3 <= (mag == '0);
			exp_s3  <= exp_s2;
		end
	end

	// Stage 4: find the leading one, work out exponent and shift
	logic [6:0]            lead;
	logic signed [EXW-1:0] e_raw, e_eff, nsh;

	always_comb begin
		lead  = msb_index(mag_s3);
		e_raw = exp_s3 + $signed({5'd0, lead}) + 12'sd74;
		e_eff = (e_raw < 12'sd1) ? 12'sd1 : e_raw;
		nsh   = e_eff - exp_s3 - 12'sd97;
	end

	logic [WINW-1:0]       mag_s4;
	logic signed [EXW-1:0] sh_s4, eff_s4;
	logic                  sign_s4, zero_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4  <= mag_s3;
			sh_s4   <= nsh;
			eff_s4  <= e_eff;
			sign_s4 <= sign_s3;
			zero_s4 <= zero_s3;
		end
	end

	// Stage 5: normalize, round and pack
	logic [EXW-1:0]  lsh;
	logic [6:0]      rsh;
	logic [RNDW-1:0] wide, sft, rmask;
	logic [23:0]     mant;
	logic            g, stk, rnd;
	logic [30:0]     res_bits;

	always_comb begin
		lsh   = 12'd0 - sh_s4;
		rsh   = (sh_s4 > 12'sd104) ? 7'd104 : sh_s4[6:0];
		wide  = {mag_s4, 2'b00};
		sft   = wide >> rsh;
		rmask = ({{(RNDW-1){1'b0}}, 1'b1} << rsh) - RNDW'(1);
		if (sh_s4 < 12'sd0) begin
			mant = mag_s4[23:0] << lsh[4:0];
			g    = 1'b0;
			stk  = 1'b0;
		end else begin
			mant = sft[25:2];
			g    = sft[1];
			stk  = sft[0] | (|(wide & rmask));
		end
		rnd      = g & (stk | mant[0]);
		res_bits = {eff_s4[7:0] - 8'd1, 23'd0} + {7'd0, mant} + {30'd0, rnd};
	end

	logic [F32W-1:0] y_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			y_s5 <= zero_s4 ? {sign_s4, 31'd0} : {sign_s4, res_bits};
		end
	end

	assign y = y_s5;

endmodule

@@ design/vfs_lane.sv @@
// One sine lane: range reduction and odd polynomial as a chain of eleven FMA units.
`timescale 1ns / 1ps
module vfs_lane import vfs_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [F32W-1:0] x,
	output logic [F32W-1:0] sine,
	output logic            oor
);

	logic [F32W-1:0] r0, n1, n2, r1, r2, r3, rr, y1, y2, y3, t, yf;
	logic [F32W-1:0] r0_d, n2_d5, n2_d10, r3_d, rr_d5, rr_d10, rr_d15;
	logic            sgn_d, oor_d, odd_d;

	assign r0 = x & ABS_MASK;

	// Rounded quotient by pi and its removal
	vfs_fma u_f1  (.clk, .en, .a(SHIFT_K), .b(INV_PI),     .c(r0),     .y(n1));
	vfs_fma u_f2  (.clk, .en, .a(n1),      .b(NEG_ONE),    .c(SHIFT_K), .y(n2));
	vfs_fma u_f3  (.clk, .en, .a(r0_d),    .b(NEG_PI_HI),  .c(n2),     .y(r1));
	vfs_fma u_f4  (.clk, .en, .a(r1),      .b(NEG_PI_MID), .c(n2_d5),  .y(r2));
	vfs_fma u_f5  (.clk, .en, .a(r2),      .b(NEG_PI_LO),  .c(n2_d10), .y(r3));

	// Odd polynomial in the reduced argument
	vfs_fma u_f6  (.clk, .en, .a(FZERO),   .b(r3),         .c(r3),     .y(rr));
	vfs_fma u_f7  (.clk, .en, .a(C7),      .b(C9),         .c(rr),     .y(y1));
	vfs_fma u_f8  (.clk, .en, .a(C5),      .b(y1),         .c(rr_d5),  .y(y2));
	vfs_fma u_f9  (.clk, .en, .a(C3),      .b(y2),         .c(rr_d10), .y(y3));
	vfs_fma u_f10 (.clk, .en, .a(FZERO),   .b(y3),         .c(rr_d15), .y(t));
	vfs_fma u_f11 (.clk, .en, .a(r3_d),    .b(t),          .c(r3_d),   .y(yf));

	// Hold operands level with the FMA chain
	vfs_delay #(.WIDTH(F32W), .DEPTH(2*FMA_LAT)) u_d_r0  (.clk, .en, .d(r0), .q(r0_d));
	vfs_delay #(.WIDTH(F32W), .DEPTH(FMA_LAT))   u_d_n5  (.clk, .en, .d(n2), .q(n2_d5));
	vfs_delay #(.WIDTH(F32W), .DEPTH(2*FMA_LAT)) u_d_n10 (.clk, .en, .d(n2), .q(n2_d10));
	vfs_delay #(.WIDTH(F32W), .DEPTH(5*FMA_LAT)) u_d_r3  (.clk, .en, .d(r3), .q(r3_d));
	vfs_delay #(.WIDTH(F32W), .DEPTH(FMA_LAT))   u_d_rr5 (.clk, .en, .d(rr), .q(rr_d5));
	vfs_delay #(.WIDTH(F32W), .DEPTH(2*FMA_LAT)) u_d_rr10 (.clk, .en, .d(rr), .q(rr_d10));
	vfs_delay #(.WIDTH(F32W), .DEPTH(3*FMA_LAT)) u_d_rr15 (.clk, .en, .d(rr), .q(rr_d15));
	vfs_delay #(.WIDTH(1), .DEPTH(LANE_LAT)) u_d_sgn (.clk, .en, .d(x[31]), .q(sgn_d));
	vfs_delay #(.WIDTH(1), .DEPTH(LANE_LAT)) u_d_oor (
		.clk, .en, .d(r0 >= RANGE_BITS), .q(oor_d)
	);
	vfs_delay #(.WIDTH(1), .DEPTH(LANE_LAT - FMA_LAT)) u_d_odd (
		.clk, .en, .d(n1[0]), .q(odd_d)
	);

	// Apply sign and parity, drop flagged lanes to zero
	assign sine = oor_d ? FZERO : (yf ^ {sgn_d ^ odd_d, 31'd0});
	assign oor  = oor_d;

endmodule

@@ test/tb_vector_float_sine.sv @@
// Testbench for the vector float sine block: random stream traffic against a bit-exact predictor.
`timescale 1ns / 1ps
module tb_vector_float_sine;
	import vfs_pkg::*;

	localparam int NL  = LANES_DEF;
	localparam int DW  = F32W * NL;
	localparam int MW  = (((F32W + 1) * NL + 7) / 8) * 8;
	localparam int N_RANDOM = 680;
	localparam int DRAIN_AT = 350;
	localparam int HOLD_AT  = 200;
	localparam int HOLD_LEN = 400;

	typedef struct packed {
		logic [NL-1:0]         mask;
		logic [NL-1:0][F32W-1:0] sine;
	} sine_result_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [DW-1:0]   s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [MW-1:0]   m_tdata;

	logic [DW-1:0]   angle_q[$];
	sine_result_t    sine_q[$];
	int              errors = 0;
	int              sent = 0;
	bit              drained = 1'b0;
	int              burst_left = 0;
	int              gap_left = 0;
	int              cycle = 0;

	vector_float_sine #(.LANES(NL)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	// Exact power of two as a double
	function automatic real pow2(input int k);
		return $bitstoreal({1'b0, 11'(1023 + k), 52'b0});
	endfunction

	// Widen a binary32 pattern to double, subnormals included
	function automatic real widen(input logic [31:0] b);
		real mag;
		if (b[30:0] == '0) return b[31] ? $bitstoreal(64'h8000000000000000) : 0.0;
		if (b[30:23] == 8'd0) mag = real'(b[22:0]) * pow2(-149);
		else mag = real'({1'b1, b[22:0]}) * pow2(int'(b[30:23]) - 150);
		return b[31] ? -mag : mag;
	endfunction

	// Round a double to binary32, nearest even, with gradual underflow
	function automatic logic [31:0] narrow(input real v);
		logic [63:0] u, sig, keep, rem, half, res;
		int fld, sh;
		u = $realtobits(v);
		if (u[62:52] == 11'd0) return {u[63], 31'b0};
		fld = int'(u[62:52]) - 1023 + 127;
		sh = 29 + (fld < 1 ? 1 - fld : 0);
		if (sh > 60) return {u[63], 31'b0};
		sig = {11'b0, 1'b1, u[51:0]};
		keep = sig >> sh;
		rem = sig & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
		if (fld < 1) res = keep;
		else res = (64'(fld - 1) << 23) + keep;
		if (res >= 64'h7f800000) res = 64'h7f800000;
		return {u[63], res[30:0]};
	endfunction

	// a + b*c with a single rounding to binary32
	function automatic logic [31:0] fma32(input logic [31:0] a, b, c);
		real p, da, s, bv, e;
		logic [63:0] u;
		p = widen(b) * widen(c);
		da = widen(a);
		s = da + p;
		bv = s - da;
		e = (da - (s - bv)) + (p - bv);
		if (e != 0.0) begin
			u = $realtobits(s);
			if (!u[0]) begin
				if ((e > 0.0) == (s > 0.0)) u = u + 64'd1;
				else u = u - 64'd1;
				s = $bitstoreal(u);
			end
		end
		return narrow(s);
	endfunction

	// Sine of one in-range lane: reduce by a split pi, then odd polynomial
	function automatic logic [31:0] lane_sine(input logic [31:0] xb);
		logic [31:0] r, n, r2, y, t;
		logic parity;
		r = xb & ABS_MASK;
		n = fma32(SHIFT_K, INV_PI, r);
		parity = n[0];
		n = fma32(n, NEG_ONE, SHIFT_K);
		r = fma32(r, NEG_PI_HI, n);
		r = fma32(r, NEG_PI_MID, n);
		r = fma32(r, NEG_PI_LO, n);
		r2 = fma32(FZERO, r, r);
		y = fma32(C7, C9, r2);
		y = fma32(C5, y, r2);
		y = fma32(C3, y, r2);
		t = fma32(FZERO, y, r2);
		y = fma32(r, t, r);
		return y ^ {xb[31] ^ parity, 31'b0};
	endfunction

	function automatic sine_result_t predict_sines(input logic [DW-1:0] req);
		sine_result_t res;
		logic [31:0] xb;
		for (int i = 0; i < NL; i++) begin
			xb = req[i*F32W +: F32W];
			if ((xb & ABS_MASK) >= RANGE_BITS) begin
				res.mask[i] = 1'b1;
				res.sine[i] = '0;
			end else begin
				res.mask[i] = 1'b0;
				res.sine[i] = lane_sine(xb);
			end
		end
		return res;
	endfunction

	// Random lane: mostly in range with a spread exponent, some raw patterns
	function automatic logic [31:0] rand_angle();
		if ($urandom_range(0, 9) < 7)
			return {1'(($urandom)), 8'($urandom_range(0, 146)), 23'($urandom)};
		return $urandom;
	endfunction

	// Offer requests in bursts; hold until accepted; pause once for a full drain
	always @(posedge clk) begin
		logic v;
		logic [DW-1:0] d;
		v = s_tvalid;
		d = s_tdata;
		if (s_tvalid && s_tready) begin
			sine_q.push_back(predict_sines(s_tdata));
			void'(angle_q.pop_front());
			sent = sent + 1;
			v = 1'b0;
		end
		if (arst_n && !(s_tvalid && !s_tready)) begin
			v = 1'b0;
			if (sent == DRAIN_AT && !drained) begin
				if (sine_q.size() == 0) drained = 1'b1;
			end else if (gap_left > 0) begin
				gap_left = gap_left - 1;
			end else if (angle_q.size() > 0) begin
				v = 1'b1;
				d = angle_q[0];
				if (burst_left > 0) burst_left = burst_left - 1;
				else begin
					burst_left = $urandom_range(0, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
		s_tvalid <= v;
		s_tdata <= d;
	end

	// Stall the result side: random phases, ready phases, one long hold
	always @(posedge clk) begin
		cycle = cycle + 1;
		if (!arst_n) m_tready <= 1'b0;
		else if (cycle >= HOLD_AT && cycle < HOLD_AT + HOLD_LEN) m_tready <= 1'b0;
		else if ((cycle / 300) % 2 == 0) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin
		sine_result_t want, got;
		if (m_tvalid && m_tready) begin
			got.sine = m_tdata[DW-1:0];
			got.mask = m_tdata[DW +: NL];
			if (sine_q.size() == 0) begin
				$error("unexpected result %h", m_tdata);
				errors = errors + 1;
			end else begin
				want = sine_q.pop_front();
				for (int i = 0; i < NL; i++)
					if (got.sine[i] !== want.sine[i]) begin
						$error("sine_lane%0d expected %h got %h", i, want.sine[i], got.sine[i]);
						errors = errors + 1;
					end
				if (got.mask !== want.mask) begin
					$error("out_of_range_mask expected %h got %h", want.mask, got.mask);
					errors = errors + 1;
				end
			end
		end
	end

	initial begin
		logic [31:0] edge_vals[$];
		logic [DW-1:0] req;
		edge_vals = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h807fffff,
			32'h3f800000, 32'hbf800000, 32'h40490fdb, 32'hc0490fdb, 32'h3fc90fdb,
			32'h497fffff, 32'h49800000, 32'hc9800000, 32'h7f7fffff, 32'h7f800000,
			32'hff800000, 32'h7fc00000, 32'hffffffff, 32'h33800000, 32'h4b400000,
			32'h40c90fdb};
		// Each edge value in lane order, rotated through lanes
		for (int k = 0; k < edge_vals.size(); k++) begin
			for (int i = 0; i < NL; i++)
				req[i*F32W +: F32W] = edge_vals[(k + i) % edge_vals.size()];
			angle_q.push_back(req);
		end
		for (int k = 0; k < N_RANDOM; k++) begin
			for (int i = 0; i < NL; i++) req[i*F32W +: F32W] = rand_angle();
			angle_q.push_back(req);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (angle_q.size() == 0 && !s_tvalid);
		wait (sine_q.size() == 0);
		repeat (LANE_LAT + 10) @(posedge clk);
		if (errors == 0) $display("vector_float_sine: match");
		else $display("vector_float_sine: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("vector_float_sine: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
design/vfs_pkg.sv
design/vfs_delay.sv
design/vfs_fma.sv
design/vfs_lane.sv
design/vector_float_sine.sv
test/tb_vector_float_sine.sv
